>>> design/exptok_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and character classes of the expression tokenizer
package exptok_pkg;

    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
    localparam int MAX_RES   = 3;

    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_DONE = 2'd2;

    localparam logic [2:0] K_NUM   = 3'd0;
    localparam logic [2:0] K_OP    = 3'd1;
    localparam logic [2:0] K_IDENT = 3'd2;
    localparam logic [2:0] K_BOOL  = 3'd3;
    localparam logic [2:0] K_STR   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_ILLEGAL   = 2'd2;

    localparam logic [3:0] KW_POS_MAX = 4'd15;
    localparam logic [3:0] FALSE_LEN  = 4'd5;
    localparam logic [3:0] TRUE_LEN   = 4'd9;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NUM   = 3'd1,
        MODE_CMP   = 3'd2,
        MODE_IDENT = 3'd3,
        MODE_STR   = 3'd4,
        MODE_ERR   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       has_point;
        logic       truth;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]              count;
        t_result [MAX_RES-1:0]   res;
    } t_push;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        logic r;
        unique case (b) inside
            "+", "-", "*", "/", "%", "^", "_", "=", "~",
            ">", "<", "&", "|", "(", ")", "[", "]", ",": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_false_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = "F";
            4'd1:    c = "a";
            4'd2:    c = "l";
            4'd3:    c = "s";
            4'd4:    c = "o";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_true_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = "V";
            4'd1:    c = "e";
            4'd2:    c = "r";
            4'd3:    c = "d";
            4'd4:    c = "a";
            4'd5:    c = "d";
            4'd6:    c = "e";
            4'd7:    c = "r";
            4'd8:    c = "o";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> design/exptok_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for text bytes and token results
interface exptok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface exptok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       has_point;
    logic       truth;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output event_res, output kind, output byte_value,
                    output has_point, output truth, output status, output last,
                    input ready);
    modport sink   (input valid, input event_res, input kind, input byte_value,
                    input has_point, input truth, input status, input last,
                    output ready);
endinterface

>>> design/expression_tokenizer_core.sv
`timescale 1ns / 1ps
// top level of the streaming expression tokenizer
//
//   channel   dir   payload                                          per transaction
//   i_text    in    text_byte                                        one text byte
//   o_res     out   event_res kind byte_value has_point truth        one result
//                   status last
//
// one text byte per cycle enters the input register and is classified the next cycle;
// it yields zero to three results, written at once into an eight-entry result queue
// the queue drains one result per cycle while the receiver is ready, so sustained
// rate is one byte per cycle while bytes average at most one result each
// a byte waits in the input register while the queue has fewer than three free slots
// synchronous active-low reset empties the input register and the result queue and returns the lexer to idle
module expression_tokenizer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    exptok_in_if.sink      i_text,
    exptok_out_if.source   o_res
);

    exptok_pkg::t_push   w_push;
    logic                w_room;

    exptok_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    exptok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_res   (o_res)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count != 2'd0) |-> w_room)
        else $error("results pushed without queue room");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.event_res == exptok_pkg::EV_DONE)) |-> o_res.last)
        else $error("done event not marked last");

    a_byte_only_on_byte_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.event_res != exptok_pkg::EV_BYTE))
        |-> (o_res.byte_value == 8'h00))
        else $error("byte value on a non-byte event");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

endmodule

>>> design/exptok_lexer.sv
`timescale 1ns / 1ps
// input register, lexer state machine and per-byte result generation
module exptok_lexer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    exptok_in_if.sink            i_text,
    input  logic                 i_room,
    output exptok_pkg::t_push    o_push
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    exptok_pkg::t_mode    r_mode, n_mode;
    logic                 r_point, n_point;
    logic [3:0]           r_kpos, n_kpos;
    logic                 r_fmatch, n_fmatch;
    logic                 r_tmatch, n_tmatch;
    logic [1:0]           r_err, n_err;

    logic fire;
    logic is_term, is_space, is_dig, is_pt, is_opc, is_cmp, is_eq, is_quote;
    logic is_ident_start, is_ident_cont;

    assign fire         = r_in_valid && i_room;
    assign i_text.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_byte <= i_text.text_byte;
        end
    end

    // character classes
    always_comb begin
        is_term        = (r_byte == 8'h00);
        is_space       = (r_byte == " ") || (r_byte == 8'h09);
        is_dig         = exptok_pkg::is_digit(r_byte);
        is_pt          = (r_byte == ".");
        is_opc         = exptok_pkg::is_op(r_byte);
        is_cmp         = (r_byte == ">") || (r_byte == "<");
        is_eq          = (r_byte == "=");
        is_quote       = (r_byte == "\"");
        is_ident_start = exptok_pkg::is_alpha(r_byte) || (r_byte == ":");
        is_ident_cont  = is_ident_start || is_dig || (r_byte == "_");
    end

    // next state
    always_comb begin
        logic do_start;
        logic do_ident;
        do_start = 1'b0;
        do_ident = 1'b0;
        n_mode   = r_mode;
        n_point  = r_point;
        n_kpos   = r_kpos;
        n_fmatch = r_fmatch;
        n_tmatch = r_tmatch;
        n_err    = r_err;
        if (is_term) begin
            n_mode   = exptok_pkg::MODE_IDLE;
            n_point  = 1'b0;
            n_kpos   = 4'd0;
            n_fmatch = 1'b0;
            n_tmatch = 1'b0;
            n_err    = exptok_pkg::ST_OK;
        end else begin
            unique case (r_mode)
                exptok_pkg::MODE_NUM: begin
                    if (is_pt) begin
                        if (r_point) begin
                            n_err  = exptok_pkg::ST_MALFORMED;
                            n_mode = exptok_pkg::MODE_ERR;
                        end else begin
                            n_point = 1'b1;
                        end
                    end else if (!is_dig) begin
                        do_start = 1'b1;
                    end
                end
                exptok_pkg::MODE_CMP: begin
                    if (is_eq) begin
                        n_mode = exptok_pkg::MODE_IDLE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                exptok_pkg::MODE_IDENT: begin
                    if (is_ident_cont) begin
                        do_ident = 1'b1;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                exptok_pkg::MODE_STR: begin
                    if (is_quote) begin
                        n_mode = exptok_pkg::MODE_IDLE;
                    end
                end
                exptok_pkg::MODE_ERR: begin
                    n_mode = exptok_pkg::MODE_ERR;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
            if (do_start) begin
                n_mode = exptok_pkg::MODE_IDLE;
                if (is_dig || is_pt) begin
                    n_mode  = exptok_pkg::MODE_NUM;
                    n_point = is_pt;
                end else if (is_opc) begin
                    n_mode = is_cmp ? exptok_pkg::MODE_CMP : exptok_pkg::MODE_IDLE;
                end else if (is_ident_start) begin
                    n_mode   = exptok_pkg::MODE_IDENT;
                    n_kpos   = 4'd1;
                    n_fmatch = (r_byte == exptok_pkg::kw_false_char(4'd0));
                    n_tmatch = (r_byte == exptok_pkg::kw_true_char(4'd0));
                end else if (is_quote) begin
                    n_mode = exptok_pkg::MODE_STR;
                end else if (!is_space) begin
                    n_err  = exptok_pkg::ST_ILLEGAL;
                    n_mode = exptok_pkg::MODE_ERR;
                end
            end
            if (do_ident) begin
                n_fmatch = r_fmatch && (r_kpos < exptok_pkg::FALSE_LEN)
                           && (exptok_pkg::kw_false_char(r_kpos) == r_byte);
                n_tmatch = r_tmatch && (r_kpos < exptok_pkg::TRUE_LEN)
                           && (exptok_pkg::kw_true_char(r_kpos) == r_byte);
                n_kpos   = r_kpos + {3'b000, (r_kpos != exptok_pkg::KW_POS_MAX)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= exptok_pkg::MODE_IDLE;
            r_point  <= 1'b0;
            r_kpos   <= 4'd0;
            r_fmatch <= 1'b0;
            r_tmatch <= 1'b0;
            r_err    <= exptok_pkg::ST_OK;
        end else if (fire) begin
            r_mode   <= n_mode;
            r_point  <= n_point;
            r_kpos   <= n_kpos;
            r_fmatch <= n_fmatch;
            r_tmatch <= n_tmatch;
            r_err    <= n_err;
        end
    end

    // results for the byte in the input register
    always_comb begin
        logic                              close_v, byte_v, end_v, done_v, do_start;
        exptok_pkg::t_result               close_r, byte_r, end_r, done_r;
        exptok_pkg::t_result [2:0]         slots;
        logic [1:0]                        n;
        close_v  = 1'b0;
        byte_v   = 1'b0;
        end_v    = 1'b0;
        done_v   = 1'b0;
        do_start = 1'b0;
        close_r  = '0;
        byte_r   = '0;
        end_r    = '0;
        done_r   = '0;
        slots    = '0;
        n        = 2'd0;

        close_r.event_res = exptok_pkg::EV_END;
        unique case (r_mode)
            exptok_pkg::MODE_NUM: begin
                close_r.kind      = exptok_pkg::K_NUM;
                close_r.has_point = r_point;
            end
            exptok_pkg::MODE_IDENT: begin
                if (r_fmatch && (r_kpos == exptok_pkg::FALSE_LEN)) begin
                    close_r.kind = exptok_pkg::K_BOOL;
                end else if (r_tmatch && (r_kpos == exptok_pkg::TRUE_LEN)) begin
                    close_r.kind  = exptok_pkg::K_BOOL;
                    close_r.truth = 1'b1;
                end else begin
                    close_r.kind = exptok_pkg::K_IDENT;
                end
            end
            exptok_pkg::MODE_STR: close_r.kind = exptok_pkg::K_STR;
            default:              close_r.kind = exptok_pkg::K_OP;
        endcase

        byte_r.event_res  = exptok_pkg::EV_BYTE;
        byte_r.byte_value = r_byte;
        end_r.event_res   = exptok_pkg::EV_END;
        end_r.kind        = exptok_pkg::K_OP;
        done_r.event_res  = exptok_pkg::EV_DONE;
        done_r.status     = r_err;

        if (is_term) begin
            close_v = (r_mode != exptok_pkg::MODE_IDLE) && (r_mode != exptok_pkg::MODE_ERR);
            done_v  = 1'b1;
        end else begin
            unique case (r_mode)
                exptok_pkg::MODE_NUM: begin
                    if (is_dig || (is_pt && !r_point)) begin
                        byte_v      = 1'b1;
                        byte_r.kind = exptok_pkg::K_NUM;
                    end else if (!is_pt) begin
                        close_v  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                exptok_pkg::MODE_CMP: begin
                    if (is_eq) begin
                        byte_v      = 1'b1;
                        byte_r.kind = exptok_pkg::K_OP;
                        end_v       = 1'b1;
                    end else begin
                        close_v  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                exptok_pkg::MODE_IDENT: begin
                    if (is_ident_cont) begin
                        byte_v      = 1'b1;
                        byte_r.kind = exptok_pkg::K_IDENT;
                    end else begin
                        close_v  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                exptok_pkg::MODE_STR: begin
                    if (is_quote) begin
                        close_v = 1'b1;
                    end else begin
                        byte_v      = 1'b1;
                        byte_r.kind = exptok_pkg::K_STR;
                    end
                end
                exptok_pkg::MODE_ERR: begin
                    byte_v = 1'b0;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
            if (do_start) begin
                if (is_dig || is_pt) begin
                    byte_v      = 1'b1;
                    byte_r.kind = exptok_pkg::K_NUM;
                end else if (is_opc) begin
                    byte_v      = 1'b1;
                    byte_r.kind = exptok_pkg::K_OP;
                    end_v       = !is_cmp;
                end else if (is_ident_start) begin
                    byte_v      = 1'b1;
                    byte_r.kind = exptok_pkg::K_IDENT;
                end
            end
        end

        if (close_v) begin
            slots[n] = close_r;
            n        = n + 2'd1;
        end
        if (byte_v) begin
            slots[n] = byte_r;
            n        = n + 2'd1;
        end
        if (end_v) begin
            slots[n] = end_r;
            n        = n + 2'd1;
        end
        if (done_v) begin
            slots[n] = done_r;
            n        = n + 2'd1;
        end
        if (n != 2'd0) begin
            slots[n - 2'd1].last = 1'b1;
        end

        o_push.res   = slots;
        o_push.count = fire ? n : 2'd0;
    end

endmodule

>>> design/exptok_fifo.sv
`timescale 1ns / 1ps
// result queue taking up to three results per cycle and giving one while the receiver is ready
module exptok_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  exptok_pkg::t_push    i_push,
    output logic                 o_room,
    exptok_out_if.source         o_res
);

    exptok_pkg::t_result                      r_mem [exptok_pkg::RES_DEPTH];
    logic [exptok_pkg::RES_PTR_W-1:0]         r_wr, r_rd;
    logic [exptok_pkg::RES_CNT_W-1:0]         r_count;
    logic                                     pop;
    exptok_pkg::t_result                      head;

    assign pop    = o_res.valid && o_res.ready;
    assign o_room = r_count <= exptok_pkg::RES_CNT_W'(exptok_pkg::RES_DEPTH
                                                      - exptok_pkg::MAX_RES);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < exptok_pkg::MAX_RES; i++) begin
            if (2'(i) < i_push.count) begin
                r_mem[r_wr + exptok_pkg::RES_PTR_W'(i)] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + exptok_pkg::RES_PTR_W'(i_push.count);
            r_rd    <= r_rd + exptok_pkg::RES_PTR_W'(pop);
            r_count <= r_count + exptok_pkg::RES_CNT_W'(i_push.count)
                       - exptok_pkg::RES_CNT_W'(pop);
        end
    end

    assign head             = r_mem[r_rd];
    assign o_res.valid      = (r_count != '0);
    assign o_res.event_res  = head.event_res;
    assign o_res.kind       = head.kind;
    assign o_res.byte_value = head.byte_value;
    assign o_res.has_point  = head.has_point;
    assign o_res.truth      = head.truth;
    assign o_res.status     = head.status;
    assign o_res.last       = head.last;

endmodule

>>> tb/expression_tokenizer_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench of expression_tokenizer_core: directed table plus random texts
module expression_tokenizer_core_test;

    localparam int          N_DIR       = 25;
    localparam int          RAND_ITEMS  = 75;
    localparam int          HOLD_CYCLES = 60;
    localparam int          STALL_LIMIT = 1000;
    localparam int          TAIL_CYCLES = 20;

    localparam string       OP_CHARS    = "+-*/%^_=~><&|()[],";
    localparam string       FALSE_WORD  = "Falso";
    localparam string       TRUE_WORD   = "Verdadero";

    localparam logic [7:0]  NUL    = 8'h00;
    localparam logic [7:0]  TAB    = 8'h09;
    localparam logic [7:0]  SPACE  = " ";
    localparam logic [7:0]  QUOTE  = 8'h22;
    localparam logic [7:0]  POINT  = ".";
    localparam logic [7:0]  COLON  = ":";
    localparam logic [7:0]  UNDER  = "_";
    localparam logic [7:0]  CH_EQ  = "=";
    localparam logic [7:0]  CH_GT  = ">";
    localparam logic [7:0]  CH_LT  = "<";

    localparam logic        CHK_FIXED = 1'b1;
    localparam logic        CHK_PRED  = 1'b0;
    localparam logic        HAS_DONE  = 1'b1;
    localparam logic        NO_DONE   = 1'b0;

    // one text byte with an optional hand-written expectation (nothing, or one done event)
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic       done_ev;
        logic [1:0] st;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    exptok_in_if  text_ch ();
    exptok_out_if res_ch ();

    expression_tokenizer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_res   (res_ch)
    );

    t_row dir_rows [N_DIR] = '{
        {NUL,   CHK_FIXED, HAS_DONE, exptok_pkg::ST_OK},
        {8'hff, CHK_FIXED, NO_DONE,  exptok_pkg::ST_OK},
        {"a",   CHK_FIXED, NO_DONE,  exptok_pkg::ST_OK},
        {NUL,   CHK_FIXED, HAS_DONE, exptok_pkg::ST_ILLEGAL},
        {"1",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {POINT, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {POINT, CHK_FIXED, NO_DONE,  exptok_pkg::ST_OK},
        {NUL,   CHK_FIXED, HAS_DONE, exptok_pkg::ST_MALFORMED},
        {CH_GT, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {CH_EQ, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {CH_LT, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {"(",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {"F",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {"a",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {"l",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {"s",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {"o",   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {TAB,   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {QUOTE, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {8'h01, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {NUL,   CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {COLON, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {UNDER, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {8'h80, CHK_PRED,  NO_DONE,  exptok_pkg::ST_OK},
        {NUL,   CHK_FIXED, HAS_DONE, exptok_pkg::ST_ILLEGAL}
    };

    exptok_pkg::t_mode   scan_mode;
    logic                scan_point;
    logic [3:0]          word_len;
    logic                maybe_false;
    logic                maybe_true;
    logic [1:0]          scan_err;

    exptok_pkg::t_result byte_tokens[$];
    exptok_pkg::t_result token_expect_q[$];
    t_row                offer_q[$];
    logic [7:0]          text_buf[$];

    bit         idle_on = 1'b1;
    bit         hold_req = 1'b0;
    int         mismatch_cnt = 0;
    int         stall_cycles = 0;
    int         bytes_in = 0;
    int         texts_done = 0;
    int         results_seen = 0;
    int         bool_ends = 0;
    int         str_ends = 0;
    int         error_texts = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // character classes
    function automatic logic dec_char(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic letter_char(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic op_char(input logic [7:0] b);
        int   i;
        logic hit;
        hit = 1'b0;
        for (i = 0; i < OP_CHARS.len(); i++)
            if (OP_CHARS[i] == b) hit = 1'b1;
        return hit;
    endfunction

    // lexer prediction
    function automatic void scan_clear();
        scan_mode   = exptok_pkg::MODE_IDLE;
        scan_point  = 1'b0;
        word_len    = '0;
        maybe_false = 1'b0;
        maybe_true  = 1'b0;
        scan_err    = exptok_pkg::ST_OK;
    endfunction

    function automatic void add_token(input logic [1:0] ev, input logic [2:0] kd,
                                      input logic [7:0] bv, input logic hp, input logic tr,
                                      input logic [1:0] st);
        exptok_pkg::t_result r;
        r            = '0;
        r.event_res  = ev;
        r.kind       = kd;
        r.byte_value = bv;
        r.has_point  = hp;
        r.truth      = tr;
        r.status     = st;
        byte_tokens.push_back(r);
    endfunction

    function automatic void word_add(input logic [7:0] b);
        if (!(word_len < exptok_pkg::FALSE_LEN && FALSE_WORD[word_len] == b))
            maybe_false = 1'b0;
        if (!(word_len < exptok_pkg::TRUE_LEN && TRUE_WORD[word_len] == b))
            maybe_true = 1'b0;
        if (word_len != exptok_pkg::KW_POS_MAX) word_len = word_len + 4'd1;
        add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_IDENT, b, 1'b0, 1'b0, '0);
    endfunction

    function automatic void close_open();
        case (scan_mode)
            exptok_pkg::MODE_NUM:
                add_token(exptok_pkg::EV_END, exptok_pkg::K_NUM, '0, scan_point, 1'b0, '0);
            exptok_pkg::MODE_CMP:
                add_token(exptok_pkg::EV_END, exptok_pkg::K_OP, '0, 1'b0, 1'b0, '0);
            exptok_pkg::MODE_IDENT: begin
                if (maybe_false && word_len == exptok_pkg::FALSE_LEN)
                    add_token(exptok_pkg::EV_END, exptok_pkg::K_BOOL, '0, 1'b0, 1'b0, '0);
                else if (maybe_true && word_len == exptok_pkg::TRUE_LEN)
                    add_token(exptok_pkg::EV_END, exptok_pkg::K_BOOL, '0, 1'b0, 1'b1, '0);
                else
                    add_token(exptok_pkg::EV_END, exptok_pkg::K_IDENT, '0, 1'b0, 1'b0, '0);
            end
            exptok_pkg::MODE_STR:
                add_token(exptok_pkg::EV_END, exptok_pkg::K_STR, '0, 1'b0, 1'b0, '0);
            default: ;
        endcase
        scan_mode = exptok_pkg::MODE_IDLE;
    endfunction

    function automatic void open_token(input logic [7:0] b);
        scan_mode = exptok_pkg::MODE_IDLE;
        if (b != SPACE && b != TAB) begin
            if (dec_char(b) || b == POINT) begin
                scan_mode  = exptok_pkg::MODE_NUM;
                scan_point = (b == POINT);
                add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_NUM, b, 1'b0, 1'b0, '0);
            end else if (op_char(b)) begin
                add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_OP, b, 1'b0, 1'b0, '0);
                if (b == CH_GT || b == CH_LT)
                    scan_mode = exptok_pkg::MODE_CMP;
                else
                    add_token(exptok_pkg::EV_END, exptok_pkg::K_OP, '0, 1'b0, 1'b0, '0);
            end else if (letter_char(b) || b == COLON) begin
                scan_mode   = exptok_pkg::MODE_IDENT;
                word_len    = '0;
                maybe_false = 1'b1;
                maybe_true  = 1'b1;
                word_add(b);
            end else if (b == QUOTE) begin
                scan_mode = exptok_pkg::MODE_STR;
            end else begin
                scan_err  = exptok_pkg::ST_ILLEGAL;
                scan_mode = exptok_pkg::MODE_ERR;
            end
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic [1:0]          st;
        exptok_pkg::t_result r;
        byte_tokens.delete();
        if (b == NUL) begin
            st = scan_err;
            if (scan_mode != exptok_pkg::MODE_ERR) close_open();
            add_token(exptok_pkg::EV_DONE, '0, '0, 1'b0, 1'b0, st);
            scan_clear();
        end else begin
            case (scan_mode)
                exptok_pkg::MODE_NUM: begin
                    if (dec_char(b)) begin
                        add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_NUM, b, 1'b0, 1'b0, '0);
                    end else if (b == POINT) begin
                        if (scan_point) begin
                            scan_err  = exptok_pkg::ST_MALFORMED;
                            scan_mode = exptok_pkg::MODE_ERR;
                        end else begin
                            scan_point = 1'b1;
                            add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_NUM, b,
                                      1'b0, 1'b0, '0);
                        end
                    end else begin
                        close_open();
                        open_token(b);
                    end
                end
                exptok_pkg::MODE_CMP: begin
                    if (b == CH_EQ) begin
                        add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_OP, b, 1'b0, 1'b0, '0);
                        close_open();
                    end else begin
                        close_open();
                        open_token(b);
                    end
                end
                exptok_pkg::MODE_IDENT: begin
                    if (letter_char(b) || dec_char(b) || b == UNDER || b == COLON) begin
                        word_add(b);
                    end else begin
                        close_open();
                        open_token(b);
                    end
                end
                exptok_pkg::MODE_STR: begin
                    if (b == QUOTE)
                        close_open();
                    else
                        add_token(exptok_pkg::EV_BYTE, exptok_pkg::K_STR, b, 1'b0, 1'b0, '0);
                end
                exptok_pkg::MODE_ERR: ;
                default: open_token(b);
            endcase
        end
        if (byte_tokens.size() > 0) begin
            r      = byte_tokens.pop_back();
            r.last = 1'b1;
            byte_tokens.push_back(r);
        end
    endfunction

    // random text generation
    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range("a", "z"));
        return 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] word_tail_char();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range("0", "9"));
            1:       return UNDER;
            2:       return COLON;
            default: return rand_letter();
        endcase
    endfunction

    function automatic void add_number();
        int unsigned len;
        int unsigned i;
        bit          dotted;
        dotted = 1'b0;
        len    = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
            if (!dotted && $urandom_range(0, 4) == 0) begin
                text_buf.push_back(POINT);
                dotted = 1'b1;
            end else begin
                text_buf.push_back(8'($urandom_range("0", "9")));
            end
        end
        if ($urandom_range(0, 9) == 0) text_buf.push_back(POINT);
    endfunction

    function automatic void add_operator();
        logic [7:0] c;
        c = OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)];
        text_buf.push_back(c);
        if ((c == CH_GT || c == CH_LT) && $urandom_range(0, 1) == 0) text_buf.push_back(CH_EQ);
    endfunction

    function automatic void add_word();
        string       kw;
        int unsigned len;
        int unsigned i;
        if ($urandom_range(0, 3) < 2) begin
            kw  = ($urandom_range(0, 1) == 0) ? FALSE_WORD : TRUE_WORD;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, kw.len() - 1) : kw.len();
            for (i = 0; i < len; i++) text_buf.push_back(kw[i]);
            if ($urandom_range(0, 4) == 0) text_buf.push_back(word_tail_char());
        end else begin
            text_buf.push_back(($urandom_range(0, 5) == 0) ? COLON : rand_letter());
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 5);
            for (i = 0; i < len; i++) text_buf.push_back(word_tail_char());
        end
    endfunction

    function automatic void add_quoted(input bit closed);
        int unsigned len;
        int unsigned i;
        logic [7:0]  c;
        text_buf.push_back(QUOTE);
        len = $urandom_range(0, 5);
        for (i = 0; i < len; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == QUOTE);
            text_buf.push_back(c);
        end
        if (closed) text_buf.push_back(QUOTE);
    endfunction

    function automatic void build_text();
        int unsigned ntok;
        int unsigned t;
        text_buf.delete();
        ntok = $urandom_range(1, 6);
        for (t = 0; t < ntok; t++) begin
            if (t > 0) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: text_buf.push_back(SPACE);
                    2: text_buf.push_back(TAB);
                    default: begin
                        text_buf.push_back(SPACE);
                        text_buf.push_back(TAB);
                    end
                endcase
            end
            case ($urandom_range(0, 13))
                0, 1, 2:    add_number();
                3, 4, 5:    add_operator();
                6, 7, 8, 9: add_word();
                10, 11, 12: add_quoted(!(t == ntok - 1 && $urandom_range(0, 1) == 0));
                default:    text_buf.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        text_buf.push_back(NUL);
    endfunction

    // checking
    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic void check_token(input exptok_pkg::t_result got);
        exptok_pkg::t_result want;
        if (token_expect_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got ev=%0d kind=%0d byte=%02h",
                     $time, got.event_res, got.kind, got.byte_value);
            mismatch_cnt++;
        end else begin
            want = token_expect_q.pop_front();
            cmp_field("event_res", want.event_res, got.event_res);
            cmp_field("kind", want.kind, got.kind);
            cmp_field("byte_value", want.byte_value, got.byte_value);
            cmp_field("has_point", want.has_point, got.has_point);
            cmp_field("truth", want.truth, got.truth);
            cmp_field("status", want.status, got.status);
            cmp_field("last", want.last, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        exptok_pkg::t_result got;
        exptok_pkg::t_result fixed;
        t_row                r;
        bit                  moved;
        moved = 1'b0;
        if (i_rst_n && text_ch.valid && text_ch.ready) begin
            moved = 1'b1;
            r     = offer_q.pop_front();
            scan_byte(text_ch.text_byte);
            if (r.typed == CHK_FIXED) begin
                if (r.done_ev == HAS_DONE) begin
                    fixed           = '0;
                    fixed.event_res = exptok_pkg::EV_DONE;
                    fixed.status    = r.st;
                    fixed.last      = 1'b1;
                    token_expect_q.push_back(fixed);
                end
            end else begin
                foreach (byte_tokens[k]) token_expect_q.push_back(byte_tokens[k]);
            end
            bytes_in++;
            if (text_ch.text_byte == NUL) texts_done++;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            moved          = 1'b1;
            got            = '0;
            got.event_res  = res_ch.event_res;
            got.kind       = res_ch.kind;
            got.byte_value = res_ch.byte_value;
            got.has_point  = res_ch.has_point;
            got.truth      = res_ch.truth;
            got.status     = res_ch.status;
            got.last       = res_ch.last;
            check_token(got);
            results_seen++;
            if (got.event_res == exptok_pkg::EV_END && got.kind == exptok_pkg::K_BOOL)
                bool_ends++;
            if (got.event_res == exptok_pkg::EV_END && got.kind == exptok_pkg::K_STR)
                str_ends++;
            if (got.event_res == exptok_pkg::EV_DONE && got.status != exptok_pkg::ST_OK)
                error_texts++;
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input t_row r);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        offer_q.push_back(r);
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= r.ch;
        @(posedge i_clk);
        while (!text_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        int i;
        int rand_bytes;
        rand_bytes        = 0;
        i_rst_n           = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = NUL;
        scan_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIR; i++) send_byte(dir_rows[i]);

        hold_req = 1'b1;
        while (rand_bytes < RAND_ITEMS) begin
            if (rand_bytes >= RAND_ITEMS - 20) idle_on = 1'b0;
            build_text();
            foreach (text_buf[k])
                send_byte({text_buf[k], CHK_PRED, NO_DONE, exptok_pkg::ST_OK});
            rand_bytes += text_buf.size();
        end
        text_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (token_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d texts, %0d bytes in, %0d results checked",
                 texts_done, bytes_in, results_seen);
        $display("  %0d boolean tokens, %0d string tokens, %0d texts ended in error",
                 bool_ends, str_ends, error_texts);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
design/exptok_pkg.sv
design/exptok_if.sv
design/exptok_lexer.sv
design/exptok_fifo.sv
design/expression_tokenizer_core.sv
tb/expression_tokenizer_core_test.sv
